// ----- rtl/fllt_pkg.sv -----
package fllt_pkg;

   // table geometry and field widths
   localparam int USER_ENTRIES    = 1024;
   localparam int COUNT_WIDTH     = 16;
   localparam int TIME_WIDTH      = 32;
   localparam int ADDR_WIDTH      = $clog2(USER_ENTRIES);
   localparam int UID_WIDTH       = 10;
   localparam int OPCODE_WIDTH    = 2;
   localparam int VERDICT_WIDTH   = 2;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DENY_LIMIT          = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LOCK_SECONDS        = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNLOCK_SECONDS      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROOT_UNLOCK_SECONDS = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MAGIC_ROOT_ENABLE   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DENY_ROOT_ENABLE    = 3'd5;

   // request word layout, lowest bit first
   localparam int REQ_UID_LSB      = 0;
   localparam int REQ_NOW_LSB      = REQ_UID_LSB + UID_WIDTH;
   localparam int REQ_CALLER_LSB   = REQ_NOW_LSB + TIME_WIDTH;
   localparam int REQ_ADMIN_LSB    = REQ_CALLER_LSB + 1;
   localparam int REQ_USED_BITS    = REQ_ADMIN_LSB + COUNT_WIDTH;
   localparam int REQ_TDATA_WIDTH  = ((REQ_USED_BITS + 7) / 8) * 8;

   // response word layout, lowest bit first
   localparam int RSP_VERDICT_LSB  = 0;
   localparam int RSP_COUNT_LSB    = RSP_VERDICT_LSB + VERDICT_WIDTH;
   localparam int RSP_LEFT_LSB     = RSP_COUNT_LSB + COUNT_WIDTH;
   localparam int RSP_USED_BITS    = RSP_LEFT_LSB + TIME_WIDTH;
   localparam int RSP_TDATA_WIDTH  = ((RSP_USED_BITS + 7) / 8) * 8;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [TIME_WIDTH-1:0]  time_type;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_FAIL,
      OP_SUCCESS,
      OP_ADMIN_SET,
      OP_QUERY
   } opcode_type;

   typedef enum logic [VERDICT_WIDTH-1:0] {
      VERDICT_PASS,
      VERDICT_OVER_LIMIT,
      VERDICT_LOCKED
   } verdict_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      count_type deny_limit;
      time_type  lock_seconds;
      time_type  unlock_seconds;
      time_type  root_unlock_seconds;
      logic      magic_root_enable;
      logic      deny_root_enable;
   } cfg_type;

   typedef struct packed {
      opcode_type             opcode;
      logic [UID_WIDTH-1:0]   user_index;
      time_type               now_seconds;
      logic                   caller_is_root;
      count_type              admin_count;
   } item_type;

   typedef struct packed {
      verdict_type verdict;
      count_type   count_new;
      time_type    time_new;
      time_type    seconds_left;
   } outcome_type;

endpackage

// ----- rtl/fllt_decide.sv -----
// Per-item decision: new entry contents, verdict and remaining lock time.
module fllt_decide import fllt_pkg::*; (
   input  cfg_type     cfg,
   input  item_type    item,
   input  count_type   old_count,
   input  time_type    old_time,
   output outcome_type outcome
);

   logic                magic;
   count_type           count_inc;
   count_type           count_fail;
   logic                is_root;
   logic                over_limit;
   time_type            unlock_span;
   logic [TIME_WIDTH:0] since;        // now - old, borrow in top bit
   logic                not_future;
   logic                unlock_ok;
   logic                lock_elapsed;
   logic                locked;
   logic [TIME_WIDTH+1:0] left_sum;
   time_type            left_sat;

   assign magic      = cfg.magic_root_enable & item.caller_is_root;
   assign count_inc  = old_count + 1'b1;
   // all-ones is never stored: the increment is taken back
   assign count_fail = (count_inc == '1) ? old_count : count_inc;
   assign is_root    = (item.user_index == '0);

   assign over_limit = (cfg.deny_limit != '0) && (count_fail > cfg.deny_limit) &&
                       (cfg.deny_root_enable || !is_root);

   assign unlock_span = is_root ? cfg.root_unlock_seconds : cfg.unlock_seconds;

   assign since      = {1'b0, item.now_seconds} - {1'b0, old_time};
   assign not_future = ~since[TIME_WIDTH];

   assign unlock_ok = (unlock_span != '0) && (old_time != '0) && not_future &&
                      (since[TIME_WIDTH-1:0] >= unlock_span);

   assign lock_elapsed = not_future && (since[TIME_WIDTH-1:0] >= cfg.lock_seconds);
   assign locked       = (cfg.lock_seconds != '0) && (old_time != '0) && !lock_elapsed;

   // lock + old - now; positive whenever locked, saturates past the time width
   assign left_sum = {2'b00, cfg.lock_seconds} + {2'b00, old_time} -
                     {2'b00, item.now_seconds};
   assign left_sat = (left_sum[TIME_WIDTH+1:TIME_WIDTH] != 2'b00) ? '1 :
                     left_sum[TIME_WIDTH-1:0];

   always_comb begin
      outcome.verdict      = VERDICT_PASS;
      outcome.count_new    = old_count;
      outcome.time_new     = old_time;
      outcome.seconds_left = '0;
      unique case (item.opcode)
         OP_FAIL: begin
            outcome.time_new = item.now_seconds;
            if (!magic) begin
               outcome.count_new = count_fail;
               if (over_limit) begin
                  if (!unlock_ok) begin
                     outcome.verdict = VERDICT_OVER_LIMIT;
                  end
               end else if (locked) begin
                  outcome.count_new    = old_count;
                  outcome.time_new     = old_time;
                  outcome.verdict      = VERDICT_LOCKED;
                  outcome.seconds_left = left_sat;
               end
            end
         end
         OP_SUCCESS: begin
            if (!magic) begin
               outcome.count_new = '0;
               outcome.time_new  = '0;
            end
         end
         OP_ADMIN_SET: begin
            if (item.admin_count == '0) begin
               outcome.count_new = '0;
               outcome.time_new  = '0;
            end else if (item.admin_count != '1) begin
               outcome.count_new = item.admin_count;
            end
         end
         OP_QUERY: begin
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- rtl/failed_login_lockout_table.sv -----
// Failed-login lockout table. Holds a failure count and last-failure time for
// each of 1024 users in two single-port tables. Each request word yields
// exactly one response word. The entry is read at the edge that accepts the
// request; then, once the response register has room, the decision is written
// back and the response is registered in the same cycle, and no new request is
// taken until that read-modify-write is done. The response register frees the
// request side once loaded; a response not yet taken stalls the write-back of
// the following item. After reset the tables are swept to zero, one entry a
// cycle, during which req_tready stays low; configuration writes are taken at
// any time (csr_ready is always high), but should only be made while no item
// is in flight.
module failed_login_lockout_table import fllt_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   // request: user_index, now_seconds, caller_is_root, admin_count
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   // request kind: opcode
   input  logic [OPCODE_WIDTH-1:0]    req_tuser,
   // response: verdict, failure_count, seconds_left
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   // register writes
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   // entry tables
   count_type count_mem [USER_ENTRIES];
   time_type  time_mem  [USER_ENTRIES];

   state_type              state_ff, state_in;
   logic [ADDR_WIDTH-1:0]  clr_addr_ff, clr_addr_in;
   cfg_type                cfg_ff;
   item_type               item_ff;
   count_type              rd_count_ff;
   time_type               rd_time_ff;
   logic                   rsp_valid_ff;
   logic [RSP_TDATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic                   req_fire;
   logic                   exec_fire;
   logic                   out_free;
   logic                   wr_en;
   logic [ADDR_WIDTH-1:0]  wr_addr;
   count_type              wr_count;
   time_type               wr_time;
   logic [ADDR_WIDTH-1:0]  rd_addr;
   outcome_type            outcome;

   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign rd_addr    = req_tdata[REQ_UID_LSB +: ADDR_WIDTH];   // index modulo table size
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // --- control ---
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      req_tready  = 1'b0;
      exec_fire   = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = item_ff.user_index[ADDR_WIDTH-1:0];
      wr_count    = outcome.count_new;
      wr_time     = outcome.time_new;
      unique case (state_ff)
         ST_CLEAR: begin
            // post-reset sweep
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_count    = '0;
            wr_time     = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_WIDTH'(USER_ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // write-back waits for room in the response register
            if (out_free) begin
               wr_en     = 1'b1;
               exec_fire = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // --- configuration registers ---
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_DENY_LIMIT:          cfg_ff.deny_limit          <= csr_data[COUNT_WIDTH-1:0];
            REG_LOCK_SECONDS:        cfg_ff.lock_seconds        <= csr_data[TIME_WIDTH-1:0];
            REG_UNLOCK_SECONDS:      cfg_ff.unlock_seconds      <= csr_data[TIME_WIDTH-1:0];
            REG_ROOT_UNLOCK_SECONDS: cfg_ff.root_unlock_seconds <= csr_data[TIME_WIDTH-1:0];
            REG_MAGIC_ROOT_ENABLE:   cfg_ff.magic_root_enable   <= csr_data[0];
            REG_DENY_ROOT_ENABLE:    cfg_ff.deny_root_enable    <= csr_data[0];
            default: begin
               // unused indexes: write dropped
            end
         endcase
      end
   end

   // --- item capture ---
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.opcode         <= opcode_type'(req_tuser);
         item_ff.user_index     <= req_tdata[REQ_UID_LSB +: UID_WIDTH];
         item_ff.now_seconds    <= req_tdata[REQ_NOW_LSB +: TIME_WIDTH];
         item_ff.caller_is_root <= req_tdata[REQ_CALLER_LSB];
         item_ff.admin_count    <= req_tdata[REQ_ADMIN_LSB +: COUNT_WIDTH];
      end
   end

   // --- tables: read on accept, write back once the response register has room ---
   always_ff @(posedge clock) begin
      if (wr_en) begin
         count_mem[wr_addr] <= wr_count;
         time_mem[wr_addr]  <= wr_time;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_count_ff <= count_mem[rd_addr];
         rd_time_ff  <= time_mem[rd_addr];
      end
   end

   fllt_decide u_decide (
      .cfg       (cfg_ff),
      .item      (item_ff),
      .old_count (rd_count_ff),
      .old_time  (rd_time_ff),
      .outcome   (outcome)
   );

   // --- response register ---
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[RSP_VERDICT_LSB +: VERDICT_WIDTH] = outcome.verdict;
      rsp_data_in[RSP_COUNT_LSB +: COUNT_WIDTH]     = outcome.count_new;
      rsp_data_in[RSP_LEFT_LSB +: TIME_WIDTH]       = outcome.seconds_left;
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ----- tb/fllt_reply_checker.sv -----
`timescale 1ns / 100ps

// Watches the register, request and response channels of the lockout table,
// keeps its own copy of the tables and limits, and checks each response word.
module fllt_reply_checker import fllt_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   input  logic [OPCODE_WIDTH-1:0]    req_tuser,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output int                         fault_count,
   output int                         words_in_flight,
   output int                         replies_checked,
   output int                         over_limit_seen,
   output int                         locked_seen
);

   typedef struct packed {
      verdict_type verdict;
      count_type   tally;
      time_type    left;
   } reply_type;

   count_type tally_mem [USER_ENTRIES];
   time_type  stamp_mem [USER_ENTRIES];

   count_type lim_deny;
   time_type  lim_lock;
   time_type  lim_unlock;
   time_type  lim_root_unlock;
   logic      magic_root_on;
   logic      deny_root_on;

   reply_type awaited_replies [$];

   function automatic logic span_passed(time_type t_old, time_type span, time_type now);
      return (t_old <= now) && ((now - t_old) >= span);
   endfunction

   // one login event against the local tables; returns the response it should give
   function automatic reply_type judge_login_event(opcode_type op, logic [UID_WIDTH-1:0] uid,
                                                   time_type now, logic caller_root,
                                                   count_type admin);
      logic [ADDR_WIDTH-1:0] slot;
      logic                  magic;
      count_type             old_cnt;
      count_type             cnt;
      time_type              old_tm;
      time_type              tm;
      time_type              span;
      logic [TIME_WIDTH+1:0] remain;
      reply_type             r;
      slot = uid[ADDR_WIDTH-1:0];
      magic = magic_root_on && caller_root;
      r.verdict = VERDICT_PASS;
      r.tally = '0;
      r.left = '0;
      case (op)
         OP_FAIL: begin
            old_cnt = tally_mem[slot];
            old_tm = stamp_mem[slot];
            cnt = old_cnt;
            tm = now;
            if (!magic) begin
               cnt = old_cnt + 1'b1;
               if (cnt == {COUNT_WIDTH{1'b1}})
                  cnt = old_cnt;
               if (lim_deny != 0 && cnt > lim_deny && (deny_root_on || uid != 0)) begin
                  span = (uid != 0) ? lim_unlock : lim_root_unlock;
                  if (!(span != 0 && old_tm != 0 && span_passed(old_tm, span, now)))
                     r.verdict = VERDICT_OVER_LIMIT;
               end else if (lim_lock != 0 && old_tm != 0 &&
                            !span_passed(old_tm, lim_lock, now)) begin
                  cnt = old_cnt;
                  tm = old_tm;
                  r.verdict = VERDICT_LOCKED;
                  // exact sum; clock running backwards can push it past the time width
                  remain = {2'b00, old_tm} + lim_lock - now;
                  r.left = (remain > {2'b00, {TIME_WIDTH{1'b1}}}) ? {TIME_WIDTH{1'b1}}
                                                                  : remain[TIME_WIDTH-1:0];
               end
            end
            tally_mem[slot] = cnt;
            stamp_mem[slot] = tm;
         end
         OP_SUCCESS: begin
            if (!magic) begin
               tally_mem[slot] = '0;
               stamp_mem[slot] = '0;
            end
         end
         OP_ADMIN_SET: begin
            if (admin == 0) begin
               tally_mem[slot] = '0;
               stamp_mem[slot] = '0;
            end else if (admin != {COUNT_WIDTH{1'b1}}) begin
               tally_mem[slot] = admin;
            end
         end
         default: ;
      endcase
      r.tally = tally_mem[slot];
      return r;
   endfunction

   always @(posedge clock) begin : watch
      reply_type want;
      reply_type got;
      int        bad;
      bad = 0;
      if (reset) begin
         for (int i = 0; i < USER_ENTRIES; i++) begin
            tally_mem[i] = '0;
            stamp_mem[i] = '0;
         end
         lim_deny = '0;
         lim_lock = '0;
         lim_unlock = '0;
         lim_root_unlock = '0;
         magic_root_on = 1'b0;
         deny_root_on = 1'b0;
         awaited_replies.delete();
         fault_count <= 0;
         words_in_flight <= 0;
         replies_checked <= 0;
         over_limit_seen <= 0;
         locked_seen <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DENY_LIMIT:          lim_deny = csr_data[COUNT_WIDTH-1:0];
               REG_LOCK_SECONDS:        lim_lock = csr_data[TIME_WIDTH-1:0];
               REG_UNLOCK_SECONDS:      lim_unlock = csr_data[TIME_WIDTH-1:0];
               REG_ROOT_UNLOCK_SECONDS: lim_root_unlock = csr_data[TIME_WIDTH-1:0];
               REG_MAGIC_ROOT_ENABLE:   magic_root_on = csr_data[0];
               REG_DENY_ROOT_ENABLE:    deny_root_on = csr_data[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            awaited_replies.push_back(judge_login_event(opcode_type'(req_tuser),
                                        req_tdata[REQ_UID_LSB +: UID_WIDTH],
                                        req_tdata[REQ_NOW_LSB +: TIME_WIDTH],
                                        req_tdata[REQ_CALLER_LSB],
                                        req_tdata[REQ_ADMIN_LSB +: COUNT_WIDTH]));
         if (rsp_tvalid && rsp_tready) begin
            got.verdict = verdict_type'(rsp_tdata[RSP_VERDICT_LSB +: VERDICT_WIDTH]);
            got.tally = rsp_tdata[RSP_COUNT_LSB +: COUNT_WIDTH];
            got.left = rsp_tdata[RSP_LEFT_LSB +: TIME_WIDTH];
            if (awaited_replies.size() == 0) begin
               $display("%0t: response word with none outstanding, expected nothing, got %0d/%0d/%0d",
                        $time, got.verdict, got.tally, got.left);
               bad++;
            end else begin
               want = awaited_replies.pop_front();
               if (got.verdict != want.verdict) begin
                  $display("%0t: verdict mismatch, expected %0d, got %0d",
                           $time, want.verdict, got.verdict);
                  bad++;
               end
               if (got.tally != want.tally) begin
                  $display("%0t: failure_count mismatch, expected %0d, got %0d",
                           $time, want.tally, got.tally);
                  bad++;
               end
               if (got.left != want.left) begin
                  $display("%0t: seconds_left mismatch, expected %0d, got %0d",
                           $time, want.left, got.left);
                  bad++;
               end
               replies_checked <= replies_checked + 1;
               if (want.verdict == VERDICT_OVER_LIMIT)
                  over_limit_seen <= over_limit_seen + 1;
               if (want.verdict == VERDICT_LOCKED)
                  locked_seen <= locked_seen + 1;
            end
         end
         fault_count <= fault_count + bad;
         words_in_flight <= awaited_replies.size();
      end
   end

endmodule

// ----- tb/tb_failed_login_lockout_table.sv -----
`timescale 1ns / 100ps

// Stimulus and verdict for the lockout table. The checker beside the block does
// all prediction; this module only drives the channels and judges the run.
module tb_failed_login_lockout_table;
   import fllt_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata;    // user_index, now_seconds, caller_is_root, admin_count
   logic [OPCODE_WIDTH-1:0]    req_tuser;    // opcode
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;    // verdict, failure_count, seconds_left
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_data;

   int fault_count;
   int words_in_flight;
   int replies_checked;
   int over_limit_seen;
   int locked_seen;

   int       cycle_count = 0;
   int       rsp_hold_cycles = 0;   // set by stimulus, served by the receiver
   int       settings_used = 0;
   time_type wall_clock;

   // a few recurring users so counts build up; root and the top index included
   logic [UID_WIDTH-1:0] user_pool [6] = '{10'd0, 10'd1, 10'd2, 10'd341, 10'd682, 10'd1023};

   failed_login_lockout_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   fllt_reply_checker reply_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .fault_count     (fault_count),
      .words_in_flight (words_in_flight),
      .replies_checked (replies_checked),
      .over_limit_seen (over_limit_seen),
      .locked_seen     (locked_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock)
      cycle_count <= cycle_count + 1;

   // watchdog
   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d words still outstanding",
               cycle_count, words_in_flight);
      $display("failed_login_lockout_table regression: fail");
      $finish;
   end

   // Response side. Alternates stretches of eager take-up with stretches of
   // random stalls; serves long hold-offs on request.
   initial begin
      int unsigned stall;
      int unsigned stretch;
      bit          eager;
      rsp_tready = 1'b0;
      stretch = 0;
      eager = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         if (stretch == 0) begin
            stretch = $urandom_range(8, 40);
            eager = ($urandom_range(0, 2) == 0);
         end
         stretch--;
         stall = eager ? 0 : $urandom_range(0, 14);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // csr_valid is left high between back-to-back writes; caller drops it
   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic write_limits(count_type deny, time_type lock, time_type unlock,
                               time_type root_unlock, logic magic, logic deny_root);
      write_reg(REG_DENY_LIMIT, CSR_DATA_WIDTH'(deny));
      write_reg(REG_LOCK_SECONDS, lock);
      write_reg(REG_UNLOCK_SECONDS, unlock);
      write_reg(REG_ROOT_UNLOCK_SECONDS, root_unlock);
      write_reg(REG_MAGIC_ROOT_ENABLE, CSR_DATA_WIDTH'(magic));
      write_reg(REG_DENY_ROOT_ENABLE, CSR_DATA_WIDTH'(deny_root));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // one request word; valid stays up after the handshake so back-to-back words
   // never see it dropped and raised in the same step
   task automatic send_word(int unsigned gap, opcode_type op, logic [UID_WIDTH-1:0] uid,
                            time_type now, logic caller_root, count_type admin);
      logic [REQ_TDATA_WIDTH-1:0] w;
      w = '0;
      w[REQ_UID_LSB +: UID_WIDTH] = uid;
      w[REQ_NOW_LSB +: TIME_WIDTH] = now;
      w[REQ_CALLER_LSB] = caller_root;
      w[REQ_ADMIN_LSB +: COUNT_WIDTH] = admin;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= w;
      req_tuser <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // stop offering and wait for every outstanding response word
   task automatic drain_replies();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_in_flight != 0) @(posedge clock);
   endtask

   task automatic random_login_events(int n, bit idle, time_type step_max);
      int unsigned          pick;
      opcode_type           op;
      logic [UID_WIDTH-1:0] uid;
      time_type             now;
      logic                 caller_root;
      count_type            admin;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         op = (pick < 55) ? OP_FAIL : (pick < 68) ? OP_SUCCESS :
              (pick < 84) ? OP_ADMIN_SET : OP_QUERY;
         uid = ($urandom_range(0, 6) < 6) ? user_pool[$urandom_range(0, 5)]
                                          : UID_WIDTH'($urandom);
         // mostly a clock that moves forward; now and then zero, noise or a step back
         pick = $urandom_range(0, 99);
         if (pick < 2)
            now = '0;
         else if (pick < 5)
            now = $urandom;
         else if (pick < 10)
            now = wall_clock - $urandom_range(0, step_max);
         else begin
            wall_clock = wall_clock + $urandom_range(0, step_max);
            now = wall_clock;
         end
         caller_root = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 9);
         if (pick < 6)
            admin = COUNT_WIDTH'($urandom_range(0, 6));
         else if (pick < 8)
            admin = COUNT_WIDTH'($urandom);
         else if (pick == 8)
            admin = {COUNT_WIDTH{1'b1}};
         else
            admin = COUNT_WIDTH'($urandom_range(65530, 65534));
         send_word(idle ? $urandom_range(0, 14) : 0, op, uid, now, caller_root, admin);
      end
   endtask

   initial begin
      time_type step;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_QUERY;
      csr_valid = 1'b0;
      csr_index = REG_DENY_LIMIT;
      csr_data = '0;
      wall_clock = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset limits first (the table sweep after reset holds these off)
      send_word(0, OP_QUERY, 10'd0, 32'd0, 1'b0, 16'd0);
      send_word(1, OP_FAIL, 10'd1023, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
      send_word(0, OP_ADMIN_SET, 10'd1023, 32'd0, 1'b0, 16'hFFFF);   // all-ones: query only
      drain_replies();

      write_limits(16'd2, 32'd50, 32'd100, 32'd300, 1'b1, 1'b0);
      send_word(0, OP_FAIL, 10'd5, 32'd1000, 1'b0, 16'd0);
      send_word(2, OP_FAIL, 10'd5, 32'd1010, 1'b0, 16'd0);        // inside lock window
      send_word(0, OP_FAIL, 10'd5, 32'd1060, 1'b0, 16'd0);
      send_word(3, OP_FAIL, 10'd5, 32'd1200, 1'b0, 16'd0);        // over limit, unlock elapsed
      send_word(0, OP_FAIL, 10'd5, 32'd1210, 1'b0, 16'd0);        // over limit, denied
      send_word(0, OP_FAIL, 10'd5, 32'd1220, 1'b1, 16'd0);        // privileged caller
      send_word(1, OP_SUCCESS, 10'd5, 32'd1230, 1'b1, 16'd0);     // privileged: no clear
      send_word(0, OP_SUCCESS, 10'd5, 32'd1240, 1'b0, 16'd0);
      send_word(0, OP_ADMIN_SET, 10'd1023, 32'd0, 1'b0, 16'd65534);
      send_word(2, OP_FAIL, 10'd1023, 32'hFFFF_FFFF, 1'b0, 16'd0); // count saturates
      send_word(0, OP_ADMIN_SET, 10'd1023, 32'd7, 1'b1, 16'd0);    // zero clears time too
      send_word(0, OP_FAIL, 10'd0, 32'hFFFF_FFF0, 1'b0, 16'd0);
      send_word(0, OP_FAIL, 10'd0, 32'd5, 1'b0, 16'd0);           // clock backwards, left saturates
      send_word(1, OP_ADMIN_SET, 10'd0, 32'd0, 1'b0, 16'd7);
      send_word(0, OP_FAIL, 10'd0, 32'd1000, 1'b0, 16'd0);        // root exempt from limit
      send_word(0, OP_QUERY, 10'd0, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
      drain_replies();

      write_limits(16'd2, 32'd50, 32'd100, 32'd300, 1'b0, 1'b1);
      send_word(0, OP_FAIL, 10'd0, 32'd5000, 1'b0, 16'd0);        // root now limited
      send_word(0, OP_FAIL, 10'd0, 32'd5400, 1'b0, 16'd0);        // root unlock elapsed
      send_word(4, OP_FAIL, 10'd0, 32'd5410, 1'b1, 16'd0);        // privileged, magic off
      send_word(0, OP_FAIL, 10'd7, 32'd0, 1'b0, 16'd0);           // failure at time zero
      drain_replies();

      // random phases, each under its own limits
      for (int p = 0; p < 8; p++) begin
         wall_clock = $urandom_range(1, 2000);
         step = 32'd40;
         case (p)
            0: write_limits('0, '0, '0, '0, 1'b0, 1'b0);
            1: begin
               write_limits(16'd65534, '1, '1, '1, 1'b1, 1'b1);
               wall_clock = $urandom;
               step = 32'h4000_0000;
            end
            2: begin
               write_limits(16'd1, 32'd1, 32'd1, 32'd1, 1'b0, 1'b1);
               step = 32'd3;
            end
            default: begin
               write_limits(($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 5)),
                            $urandom_range(0, 40), $urandom_range(0, 150),
                            $urandom_range(0, 250), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
               step = $urandom_range(5, 60);
               if (p == 7)
                  wall_clock = 32'hFFFF_F000;   // let the clock wrap
            end
         endcase
         // long response hold-off while words keep coming, so the request side backs up
         if (p == 4) begin
            rsp_hold_cycles = 300;
            random_login_events(24, 1'b0, step);
         end
         random_login_events(105, p % 3 != 0, step);
         drain_replies();
      end

      repeat (8) @(posedge clock);
      $display("%0d response words checked under %0d limit settings",
               replies_checked, settings_used);
      $display("%0d over-limit denials and %0d lock-window refusals seen",
               over_limit_seen, locked_seen);
      if (fault_count == 0 && words_in_flight == 0)
         $display("failed_login_lockout_table regression: pass");
      else
         $display("failed_login_lockout_table regression: fail");
      $finish;
   end

endmodule
